// File: rtl/spmacc_pkg.sv
// Shared widths, register addresses and types for scaled_plaintext_mod_accumulate.
// No dependencies.
`timescale 1ns / 1ps
package spmacc_pkg;
   localparam int RES_W   = 61;
   localparam int COEF_W  = 60;
   localparam int ADDR_W  = 5;
   localparam int STAGE_A = RES_W;
   localparam int STAGE_B = COEF_W;

   typedef enum logic [1:0] {
      REG_MODULUS   = 2'd0,
      REG_SCALE     = 2'd1,
      REG_THRESHOLD = 2'd2,
      REG_OFFSET    = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [COEF_W-1:0] coeff;
      logic [RES_W-1:0]  residue;
      logic              upper;
      logic              last;
   } side_a_type;

   typedef struct packed {
      logic [COEF_W-1:0] coeff;
      logic [RES_W-1:0]  delta_red;
      logic [RES_W-1:0]  res_red;
      logic [RES_W-1:0]  off_red;
      logic              upper;
      logic              last;
   } side_b_type;
endpackage

// File: rtl/spmacc_cell.sv
// One modular Horner cell: acc_out = (2*acc_in + bit*addend) mod q, registered.
// Depends on spmacc_pkg.
`timescale 1ns / 1ps
module spmacc_cell (
   input  logic                        clock,
   input  logic                        en,
   input  logic [spmacc_pkg::RES_W-1:0] q,
   input  logic [spmacc_pkg::RES_W-1:0] acc_in,
   input  logic                        bit_in,
   input  logic [spmacc_pkg::RES_W-1:0] addend,
   output logic [spmacc_pkg::RES_W-1:0] acc_out
);
   logic [spmacc_pkg::RES_W-1:0] acc_ff, acc_in_w;
   logic [spmacc_pkg::RES_W+2:0] s, q1, q2;

   always_comb begin
      s  = {2'b00, acc_in, 1'b0} + (bit_in ? {3'b000, addend} : '0);
      q1 = {3'b000, q};
      q2 = {2'b00, q, 1'b0};
      if (s >= q2) begin
         acc_in_w = spmacc_pkg::RES_W'(s - q2);
      end else if (s >= q1) begin
         acc_in_w = spmacc_pkg::RES_W'(s - q1);
      end else begin
         acc_in_w = spmacc_pkg::RES_W'(s);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in_w;
      end
   end

   assign acc_out = acc_ff;
endmodule

// File: rtl/scaled_plaintext_mod_accumulate.sv
// Pipeline: 61 reduction cells per chain, 60 multiply cells and an output register;
// the first cell loads on the accepting edge.
// Throughput: one request per cycle; the whole cell chain stalls only while a result waits.
// Reset clears valid bits and sets the modulus register to 2, the other CSRs to 0.
// Depends on spmacc_pkg, spmacc_cell.
`timescale 1ns / 1ps
module scaled_plaintext_mod_accumulate (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [127:0]                    req_tdata, // plain_coeff[59:0], residue_in[120:60]
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata, // residue_out[60:0]
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [spmacc_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [63:0]                     csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready
);
   localparam int W  = spmacc_pkg::RES_W;
   localparam int NA = spmacc_pkg::STAGE_A;
   localparam int NB = spmacc_pkg::STAGE_B;

   logic [W-1:0] mod_ff, scale_ff, thr_ff, off_ff;
   logic         adv;
   logic [NA-1:0] va_ff;
   logic [NB-1:0] vb_ff;
   spmacc_pkg::side_a_type sa_ff [NA];
   spmacc_pkg::side_b_type sb_ff [NB];
   logic [W-1:0] dacc [NA];
   logic [W-1:0] racc [NA];
   logic [W-1:0] oacc [NA];
   logic [W-1:0] macc [NB];
   logic         rsp_tvalid_ff, rsp_tlast_ff;
   logic [W-1:0] rsp_data_ff, rsp_data_in;
   logic [W+1:0] sum, q1, q2;
   logic [spmacc_pkg::COEF_W-1:0] in_coeff;
   logic [W-1:0] in_res;
   spmacc_pkg::reg_idx_type widx;

   assign csr_pready = 1'b1;
   assign widx       = spmacc_pkg::reg_idx_type'(csr_paddr[4:3]);
   always_comb begin
      unique case (widx)
         spmacc_pkg::REG_MODULUS:   csr_prdata = {3'b000, mod_ff};
         spmacc_pkg::REG_SCALE:     csr_prdata = {3'b000, scale_ff};
         spmacc_pkg::REG_THRESHOLD: csr_prdata = {3'b000, thr_ff};
         default:                   csr_prdata = {3'b000, off_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff   <= W'(2);
         scale_ff <= '0;
         thr_ff   <= '0;
         off_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (widx)
            spmacc_pkg::REG_MODULUS:   mod_ff   <= W'(csr_pwdata);
            spmacc_pkg::REG_SCALE:     scale_ff <= W'(csr_pwdata);
            spmacc_pkg::REG_THRESHOLD: thr_ff   <= W'(csr_pwdata);
            default:                   off_ff   <= W'(csr_pwdata);
         endcase
      end
   end

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv && !reset;
   assign in_coeff   = req_tdata[spmacc_pkg::COEF_W-1:0];
   assign in_res     = req_tdata[spmacc_pkg::COEF_W+W-1:spmacc_pkg::COEF_W];

   genvar k;
   generate
      for (k = 0; k < NA; k++) begin : g_a
         spmacc_cell u_d (.clock(clock), .en(adv), .q(mod_ff),
            .acc_in(k == 0 ? '0 : dacc[k == 0 ? 0 : k-1]), .bit_in(scale_ff[NA-1-k]),
            .addend(W'(1)), .acc_out(dacc[k]));
         spmacc_cell u_r (.clock(clock), .en(adv), .q(mod_ff),
            .acc_in(k == 0 ? '0 : racc[k == 0 ? 0 : k-1]),
            .bit_in(k == 0 ? in_res[NA-1] : sa_ff[k == 0 ? 0 : k-1].residue[NA-1-k]),
            .addend(W'(1)), .acc_out(racc[k]));
         spmacc_cell u_o (.clock(clock), .en(adv), .q(mod_ff),
            .acc_in(k == 0 ? '0 : oacc[k == 0 ? 0 : k-1]), .bit_in(off_ff[NA-1-k]),
            .addend(W'(1)), .acc_out(oacc[k]));
         always_ff @(posedge clock) begin
            if (adv) begin
               if (k == 0) begin
                  sa_ff[k].coeff   <= in_coeff;
                  sa_ff[k].residue <= in_res;
                  sa_ff[k].upper   <= {1'b0, in_coeff} >= thr_ff;
                  sa_ff[k].last    <= req_tlast;
               end else begin
                  sa_ff[k] <= sa_ff[k == 0 ? 0 : k-1];
               end
            end
            if (reset) begin
               va_ff[k] <= 1'b0;
            end else if (adv) begin
               va_ff[k] <= (k == 0) ? req_tvalid : va_ff[k == 0 ? 0 : k-1];
            end
         end
      end

      for (k = 0; k < NB; k++) begin : g_b
         spmacc_cell u_m (.clock(clock), .en(adv), .q(mod_ff),
            .acc_in(k == 0 ? '0 : macc[k == 0 ? 0 : k-1]),
            .bit_in(k == 0 ? sa_ff[NA-1].coeff[NB-1] : sb_ff[k == 0 ? 0 : k-1].coeff[NB-1-k]),
            .addend(k == 0 ? dacc[NA-1] : sb_ff[k == 0 ? 0 : k-1].delta_red),
            .acc_out(macc[k]));
         always_ff @(posedge clock) begin
            if (adv) begin
               if (k == 0) begin
                  sb_ff[k].coeff     <= sa_ff[NA-1].coeff;
                  sb_ff[k].delta_red <= dacc[NA-1];
                  sb_ff[k].res_red   <= racc[NA-1];
                  sb_ff[k].off_red   <= oacc[NA-1];
                  sb_ff[k].upper     <= sa_ff[NA-1].upper;
                  sb_ff[k].last      <= sa_ff[NA-1].last;
               end else begin
                  sb_ff[k] <= sb_ff[k == 0 ? 0 : k-1];
               end
            end
            if (reset) begin
               vb_ff[k] <= 1'b0;
            end else if (adv) begin
               vb_ff[k] <= (k == 0) ? va_ff[NA-1] : vb_ff[k == 0 ? 0 : k-1];
            end
         end
      end
   endgenerate

   always_comb begin
      sum = {2'b00, macc[NB-1]} + {2'b00, sb_ff[NB-1].res_red}
          + (sb_ff[NB-1].upper ? {2'b00, sb_ff[NB-1].off_red} : '0);
      q1  = {2'b00, mod_ff};
      q2  = {1'b0, mod_ff, 1'b0};
      if (mod_ff < W'(2)) begin
         rsp_data_in = '0;
      end else if (sum >= q2) begin
         rsp_data_in = W'(sum - q2);
      end else if (sum >= q1) begin
         rsp_data_in = W'(sum - q1);
      end else begin
         rsp_data_in = W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= vb_ff[NB-1];
      end
      if (adv) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_tlast_ff <= sb_ff[NB-1].last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};
   assign rsp_tlast  = rsp_tlast_ff;
endmodule
